### src/tsre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_pkg
// shared types, constants and the per-qubit pauli product exponent
// ----------------------------------------------------------------------------
package tsre_pkg;

	localparam int QUBITS_DEF = 64;

	localparam int ACTION_W = 2;
	localparam int ROW_IDX_W = 8;
	localparam int GEN_W = 7;
	localparam int NQ_W = 7;
	localparam int PHASE_W = 2;

	localparam logic [NQ_W-1:0] QUBIT_COUNT_RST = 7'd64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_COPY = 2'd0,
		ACT_SWAP = 2'd1,
		ACT_SET  = 2'd2,
		ACT_MUL  = 2'd3
	} action_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic rd_k;
		logic rd_i;
		logic cap_k;
		logic cap_i;
		logic wr_top;
		logic wr_k;
		logic wr_i;
		logic res_zero;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic                item_ok;
		action_t             action;
		logic [PHASE_W-1:0]  phase;
	} status_t;

	// exponent of i picked up when multiplying pauli (xk,zk) into (xi,zi)
	function automatic logic [1:0] pauli_exp(input logic xk, input logic zk,
			input logic xi, input logic zi);
		logic [1:0] e;
		e = 2'd0;
		unique case ({xk, zk})
			2'b10: begin
				if (xi && zi) e = 2'd1;
				else if (!xi && zi) e = 2'd3;
			end
			2'b11: begin
				if (!xi && zi) e = 2'd1;
				else if (xi && !zi) e = 2'd3;
			end
			2'b01: begin
				if (xi && !zi) e = 2'd1;
				else if (xi && zi) e = 2'd3;
			end
			2'b00: e = 2'd0;
		endcase
		return e;
	endfunction

endpackage

### src/tsre_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre channel interfaces
// valid/ready channels for action words, result words and configuration
// ----------------------------------------------------------------------------
interface tsre_item_if;
	logic                               valid;
	logic                               ready;
	logic [tsre_pkg::ACTION_W-1:0]      action;
	logic [tsre_pkg::ROW_IDX_W-1:0]     row_i;
	logic [tsre_pkg::ROW_IDX_W-1:0]     row_k;
	logic [tsre_pkg::GEN_W-1:0]         generator_index;

	modport source (output valid, output action, output row_i, output row_k,
		output generator_index, input ready);
	modport sink (input valid, input action, input row_i, input row_k,
		input generator_index, output ready);
endinterface

interface tsre_result_if;
	logic                               valid;
	logic                               ready;
	logic [tsre_pkg::PHASE_W-1:0]       phase_out;

	modport source (output valid, output phase_out, input ready);
	modport sink (input valid, input phase_out, output ready);
endinterface

interface tsre_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tsre_pkg::NQ_W-1:0]          data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/stabilizer_tableau_row_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stabilizer_tableau_row_engine_top
// stabilizer tableau row engine: copy, swap, set generator and rowsum
// ----------------------------------------------------------------------------
// The tableau lives in one row memory of 2*QUBITS+1 rows, each row holding
// QUBITS x bits, QUBITS z bits and a 2-bit phase; row 2n is the scratch row.
// One action word is taken at a time and returns one result word, the new
// phase of row i. Every row access goes through the single read port and the
// single write port of that memory: set writes row i; copy and multiply read
// row k, then row i, and write row i; swap reads both and writes the scratch
// row, row k and row i; a word with row i, or (but for set) row k, above 2n
// changes nothing (phase 0). The result sits in an output register, so the
// next action word is accepted while the previous result still waits. Rows
// must be written (copy into them, set or swap) before they are read. The
// qubit count may be written through the configuration channel only while
// no action is in flight; 0 acts as 1 and values above QUBITS act as QUBITS.
// ----------------------------------------------------------------------------
module stabilizer_tableau_row_engine_top #(
	parameter int QUBITS = tsre_pkg::QUBITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tsre_item_if.sink     item,
	tsre_result_if.source result,
	tsre_cfg_if.sink      cfg
);

	tsre_pkg::cmd_t    cmd;
	tsre_pkg::status_t status;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	// sequencer: handshakes, action sequencing, result word register
	tsre_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.result_phase (result.phase_out),
		.cmd          (cmd),
		.status       (status)
	);

	// datapath: row memory, operand rows, phase sum, write-back
	tsre_datapath #(
		.QUBITS (QUBITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.action          (item.action),
		.row_i           (item.row_i),
		.row_k           (item.row_k),
		.generator_index (item.generator_index),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.data),
		.cmd             (cmd),
		.status          (status)
	);

endmodule

### src/tsre_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module tsre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

### src/tsre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_ctrl
// action sequencer and result word register
// ----------------------------------------------------------------------------
module tsre_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [tsre_pkg::PHASE_W-1:0] result_phase,
	output tsre_pkg::cmd_t               cmd,
	input  tsre_pkg::status_t            status
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DECODE = 9'b000000010,
		ST_RD_K   = 9'b000000100,
		ST_RD_I   = 9'b000001000,
		ST_LOAD   = 9'b000010000,
		ST_WR_TOP = 9'b000100000,
		ST_WR_K   = 9'b001000000,
		ST_WR_I   = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t                       state_q, state_d;
	logic                         out_valid_q;
	logic [tsre_pkg::PHASE_W-1:0] out_phase_q;
	logic                         out_load;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!status.item_ok) begin
					cmd.res_zero = 1'b1;
					state_d      = ST_DONE;
				end else if (status.action == tsre_pkg::ACT_SET) begin
					state_d = ST_WR_I;
				end else begin
					state_d = ST_RD_K;
				end
			end
			ST_RD_K: begin
				cmd.rd_k = 1'b1;
				state_d  = ST_RD_I;
			end
			ST_RD_I: begin
				cmd.rd_i  = 1'b1;
				cmd.cap_k = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.cap_i = 1'b1;
				if (status.action == tsre_pkg::ACT_SWAP) state_d = ST_WR_TOP;
				else state_d = ST_WR_I;
			end
			ST_WR_TOP: begin
				cmd.wr_top = 1'b1;
				state_d    = ST_WR_K;
			end
			ST_WR_K: begin
				cmd.wr_k = 1'b1;
				state_d  = ST_WR_I;
			end
			ST_WR_I: begin
				cmd.wr_i = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_phase_q <= status.phase;
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result_phase = out_phase_q;

endmodule

### src/tsre_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_datapath
// row memory, operand registers, phase sum tree and write-back mux
// ----------------------------------------------------------------------------
module tsre_datapath #(
	parameter int QUBITS = tsre_pkg::QUBITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [tsre_pkg::ACTION_W-1:0]  action,
	input  logic [tsre_pkg::ROW_IDX_W-1:0] row_i,
	input  logic [tsre_pkg::ROW_IDX_W-1:0] row_k,
	input  logic [tsre_pkg::GEN_W-1:0]     generator_index,
	input  logic                           cfg_we,
	input  logic [tsre_pkg::NQ_W-1:0]      cfg_data,
	input  tsre_pkg::cmd_t                 cmd,
	output tsre_pkg::status_t              status
);

	localparam int ROWS    = 2 * QUBITS + 1;
	localparam int ADDR_W  = $clog2(ROWS);
	localparam int ROW_W   = 2 * QUBITS + 2;
	localparam int PH_LO   = 2 * QUBITS;
	localparam int LEAF_LG = $clog2(QUBITS);
	localparam int LEAVES  = 1 << LEAF_LG;
	localparam logic [QUBITS-1:0] ROW_ONE = QUBITS'(1);

	logic [tsre_pkg::NQ_W-1:0]      qubit_count_q;
	logic [tsre_pkg::NQ_W-1:0]      n_eff;
	tsre_pkg::action_t              action_q;
	logic [tsre_pkg::ROW_IDX_W-1:0] row_i_q, row_k_q, top_q;
	logic [tsre_pkg::GEN_W-1:0]     gen_q;
	logic [tsre_pkg::NQ_W-1:0]      n_q;

	logic [ROW_W-1:0]  rd_data, k_row_q, i_row_q, wdata;
	logic [ADDR_W-1:0] waddr, raddr;
	logic              we;
	logic [QUBITS-1:0] qmask, set_x, set_z;
	logic [1:0]        contrib_q [QUBITS];
	logic [1:0]        node [2*LEAVES-1];
	logic [1:0]        mul_phase;
	logic [1:0]        res_phase_q;

	// qubit count clamped to 1..QUBITS
	always_comb begin
		if (qubit_count_q == '0) n_eff = 7'd1;
		else if (int'(qubit_count_q) > QUBITS) n_eff = 7'(QUBITS);
		else n_eff = qubit_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qubit_count_q <= tsre_pkg::QUBIT_COUNT_RST;
		end else if (cfg_we) begin
			qubit_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			action_q <= tsre_pkg::action_t'(action);
			row_i_q  <= row_i;
			row_k_q  <= row_k;
			gen_q    <= generator_index;
			n_q      <= n_eff;
			top_q    <= {n_eff, 1'b0};
		end
		if (cmd.cap_k) k_row_q <= rd_data;
		if (cmd.cap_i) i_row_q <= rd_data;
		if (cmd.res_zero) res_phase_q <= 2'd0;
		else if (cmd.wr_i) res_phase_q <= wdata[ROW_W-1:PH_LO];
	end

	// per-qubit exponent, masked to the qubits in use
	for (genvar q = 0; q < QUBITS; q++) begin : g_qubit
		assign qmask[q] = (q < int'(n_q));
		always_ff @(posedge clk) begin
			if (cmd.cap_i) begin
				contrib_q[q] <= qmask[q] ?
					tsre_pkg::pauli_exp(k_row_q[q], k_row_q[QUBITS+q],
						rd_data[q], rd_data[QUBITS+q]) : 2'd0;
			end
		end
	end

	// mod 4 adder tree over the registered exponents
	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		if (j < QUBITS) begin : g_used
			assign node[LEAVES-1+j] = contrib_q[j];
		end else begin : g_pad
			assign node[LEAVES-1+j] = 2'd0;
		end
	end
	for (genvar m = 0; m < LEAVES - 1; m++) begin : g_node
		assign node[m] = node[2*m+1] + node[2*m+2];
	end

	assign mul_phase = node[0] + i_row_q[ROW_W-1:PH_LO] + k_row_q[ROW_W-1:PH_LO];

	// generator bit: x below n, z below 2n, nothing above
	assign set_x = (gen_q < n_q) ? (ROW_ONE << gen_q) : '0;
	assign set_z = (gen_q >= n_q && {1'b0, gen_q} < top_q) ?
		(ROW_ONE << (gen_q - n_q)) : '0;

	always_comb begin
		waddr = ADDR_W'(row_i_q);
		wdata = k_row_q;
		if (cmd.wr_top) begin
			waddr = ADDR_W'(top_q);
			wdata = k_row_q;
		end else if (cmd.wr_k) begin
			// when row i is the scratch row it already holds old row k
			waddr = ADDR_W'(row_k_q);
			wdata = (row_i_q == top_q) ? k_row_q : i_row_q;
		end else begin
			unique case (action_q)
				tsre_pkg::ACT_COPY: wdata = k_row_q;
				tsre_pkg::ACT_SWAP: wdata = (row_k_q == top_q) ? i_row_q : k_row_q;
				tsre_pkg::ACT_SET:  wdata = {2'b00, set_z, set_x};
				tsre_pkg::ACT_MUL:  wdata = {mul_phase,
					i_row_q[PH_LO-1:0] ^ k_row_q[PH_LO-1:0]};
				default:            wdata = k_row_q;
			endcase
		end
	end

	assign we    = cmd.wr_top | cmd.wr_k | cmd.wr_i;
	assign raddr = cmd.rd_i ? ADDR_W'(row_i_q) : ADDR_W'(row_k_q);

	tsre_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_row_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_k | cmd.rd_i),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign status.item_ok = (row_i_q <= top_q) &&
		(action_q == tsre_pkg::ACT_SET || row_k_q <= top_q);
	assign status.action  = action_q;
	assign status.phase   = res_phase_q;

endmodule

### src/tsre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsre_checker
// port-level checks on the row engine, bound to the top level
// ----------------------------------------------------------------------------
module tsre_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] phase_out
);

	// result word holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped before taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(phase_out))
		else $error("stalled result word changed");

	// one action at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second word taken while an action is in flight");

	// no result can come out in the cycle right after acceptance
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(result_valid))
		else $error("result word appeared too early");

endmodule

bind stabilizer_tableau_row_engine_top tsre_checker u_tsre_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.phase_out    (result.phase_out)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stabilizer tableau row engine: action words go
// in through a bursty driver, the phase words that come back are compared
// with a behavioral tableau kept in the bench, over several qubit counts
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QUBITS = tsre_pkg::QUBITS_DEF;
	localparam int LAST_ROW = 2 * QUBITS;
	localparam int PHASES = 9;
	localparam int OPS_PER_PHASE = 130;

	// one action word as the driver presents it
	typedef struct packed {
		tsre_pkg::action_t                act;
		logic [tsre_pkg::ROW_IDX_W-1:0]   row_i;
		logic [tsre_pkg::ROW_IDX_W-1:0]   row_k;
		logic [tsre_pkg::GEN_W-1:0]       gen;
	} row_op_t;

	// expected phase word, with the action word that caused it for reports
	typedef struct packed {
		row_op_t                          op;
		logic [tsre_pkg::PHASE_W-1:0]     phase;
	} phase_due_t;

	logic clk = 1'b0;
	logic arst_n;

	tsre_item_if   item_ch ();
	tsre_result_if res_ch ();
	tsre_cfg_if    cfg_ch ();

	stabilizer_tableau_row_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	// bench copy of the tableau, updated at each accepted action word
	logic [QUBITS-1:0]            tab_x  [0:LAST_ROW];
	logic [QUBITS-1:0]            tab_z  [0:LAST_ROW];
	logic [tsre_pkg::PHASE_W-1:0] tab_ph [0:LAST_ROW];
	logic [tsre_pkg::NQ_W-1:0]    qubit_cfg = tsre_pkg::QUBIT_COUNT_RST;

	// rows that the stimulus has already written, so reads stay legal
	logic row_filled [0:LAST_ROW];

	row_op_t    op_queue [$];
	phase_due_t phase_due_q [$];

	int ops_queued = 0;
	int ops_taken = 0;
	int phases_checked = 0;
	int dropped_cnt = 0;
	int bad_cnt = 0;
	int act_cnt [4] = '{0, 0, 0, 0};
	logic item_fire = 1'b0;

	// ------------------------------------------------------------------------
	// tableau predictor
	// ------------------------------------------------------------------------

	// power of i picked up when pauli (xk,zk) of row k multiplies (xi,zi)
	function automatic int pauli_phase(logic xk, logic zk, logic xi, logic zi);
		case ({xk, zk, xi, zi})
			4'b1011, 4'b1101, 4'b0110: return 1;
			4'b1001, 4'b1110, 4'b0111: return 3;
			default: return 0;
		endcase
	endfunction

	task automatic copy_row(int dst, int src);
		tab_x[dst]  = tab_x[src];
		tab_z[dst]  = tab_z[src];
		tab_ph[dst] = tab_ph[src];
	endtask

	function automatic int eff_qubits(int raw);
		if (raw < 1)
			return 1;
		if (raw > QUBITS)
			return QUBITS;
		return raw;
	endfunction

	// true when a row index is above 2n and the word leaves the tableau alone
	function automatic bit is_dropped(row_op_t op, int n);
		return (op.row_i > 2 * n) ||
			(op.act != tsre_pkg::ACT_SET && op.row_k > 2 * n);
	endfunction

	task automatic apply_row_op(input row_op_t op,
			output logic [tsre_pkg::PHASE_W-1:0] ph);
		int n, top, i, k, e;
		n = eff_qubits(qubit_cfg);
		top = 2 * n;
		i = op.row_i;
		k = op.row_k;
		ph = '0;
		if (is_dropped(op, n))
			return;
		case (op.act)
			tsre_pkg::ACT_COPY: copy_row(i, k);
			tsre_pkg::ACT_SWAP: begin
				// through the scratch row, in this order
				copy_row(top, k);
				copy_row(k, i);
				copy_row(i, top);
			end
			tsre_pkg::ACT_SET: begin
				tab_x[i] = '0;
				tab_z[i] = '0;
				tab_ph[i] = '0;
				if (op.gen < n)
					tab_x[i][op.gen] = 1'b1;
				else if (op.gen < top)
					tab_z[i][op.gen - n] = 1'b1;
			end
			default: begin
				e = tab_ph[i] + tab_ph[k];
				for (int q = 0; q < n; q++)
					e += pauli_phase(tab_x[k][q], tab_z[k][q], tab_x[i][q], tab_z[i][q]);
				tab_ph[i] = e[1:0];
				tab_x[i] ^= tab_x[k];
				tab_z[i] ^= tab_z[k];
			end
		endcase
		ph = tab_ph[i];
	endtask

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic row_op_t row_op(tsre_pkg::action_t a, int i, int k, int g);
		row_op_t op;
		op.act = a;
		op.row_i = tsre_pkg::ROW_IDX_W'(i);
		op.row_k = tsre_pkg::ROW_IDX_W'(k);
		op.gen = tsre_pkg::GEN_W'(g);
		return op;
	endfunction

	function automatic int pick_written(int top);
		int cand [$];
		for (int r = 0; r <= top; r++)
			if (row_filled[r])
				cand.push_back(r);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(cand.size() - 1)];
	endfunction

	// queue a word and track which rows it writes
	task automatic push_op(row_op_t op, int n);
		op_queue.push_back(op);
		ops_queued++;
		if (is_dropped(op, n))
			return;
		row_filled[op.row_i] = 1'b1;
		if (op.act == tsre_pkg::ACT_SWAP) begin
			row_filled[op.row_k] = 1'b1;
			row_filled[2 * n] = 1'b1;
		end
	endtask

	// mostly legal words on written rows, some with indices beyond 2n
	function automatic row_op_t make_op(int n);
		row_op_t op;
		int top, w1, w2;
		top = 2 * n;
		op.act = tsre_pkg::action_t'($urandom_range(3));
		op.row_i = tsre_pkg::ROW_IDX_W'($urandom_range(top));
		op.row_k = tsre_pkg::ROW_IDX_W'($urandom_range(top));
		// now and then a generator index anywhere in 0..127 (at or above 2n it clears the row)
		op.gen = tsre_pkg::GEN_W'(($urandom_range(7) == 0) ?
			$urandom_range(127) : $urandom_range(top - 1));
		if ($urandom_range(99) < 8) begin
			if ($urandom_range(1))
				op.row_i = tsre_pkg::ROW_IDX_W'($urandom_range(255, top + 1));
			else
				op.row_k = tsre_pkg::ROW_IDX_W'($urandom_range(255, top + 1));
			return op;
		end
		w1 = pick_written(top);
		w2 = pick_written(top);
		if (w1 < 0)
			op.act = tsre_pkg::ACT_SET;
		case (op.act)
			tsre_pkg::ACT_COPY: op.row_k = tsre_pkg::ROW_IDX_W'(w1);
			tsre_pkg::ACT_SWAP, tsre_pkg::ACT_MUL: begin
				op.row_i = tsre_pkg::ROW_IDX_W'(w1);
				op.row_k = tsre_pkg::ROW_IDX_W'(($urandom_range(5) == 0) ? w1 : w2);
			end
			default: ;
		endcase
		return op;
	endfunction

	task automatic flag_error(string what);
		if (bad_cnt < 10)
			$display("[%0t] ERROR %s", $realtime, what);
		bad_cnt++;
	endtask

	// wait until every queued word is taken and every phase word is back,
	// then let the engine settle
	task automatic drain();
		while (ops_taken != ops_queued || phase_due_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// action word driver: bursts of random length, random gaps between them
	// ------------------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		row_op_t cur;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (op_queue.size() != 0) begin
				cur = op_queue.pop_front();
				item_ch.action          <= cur.act;
				item_ch.row_i           <= cur.row_i;
				item_ch.row_k           <= cur.row_k;
				item_ch.generator_index <= cur.gen;
				item_ch.valid           <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(24, 1);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
				end else begin
					burst_left--;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// phase word receiver: a stall mode is picked at random and held for a random span
	// (always ready, mostly ready, mostly stalled)
	// ------------------------------------------------------------------------
	int stall_mode = 0;
	int stall_span = 0;

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = $urandom_range(2);
			stall_span = $urandom_range(300, 30);
		end else begin
			stall_span--;
		end
		case (stall_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(3) != 0);
			default: res_ch.ready <= ($urandom_range(5) == 0);
		endcase
	end

	// ------------------------------------------------------------------------
	// monitor: config writes, accepted action words, returned phase words
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		row_op_t op;
		phase_due_t due;
		logic [tsre_pkg::PHASE_W-1:0] want;
		item_fire <= item_ch.valid && item_ch.ready;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				qubit_cfg = cfg_ch.data;
			if (item_ch.valid && item_ch.ready) begin
				op.act = tsre_pkg::action_t'(item_ch.action);
				op.row_i = item_ch.row_i;
				op.row_k = item_ch.row_k;
				op.gen = item_ch.generator_index;
				apply_row_op(op, want);
				if (is_dropped(op, eff_qubits(qubit_cfg)))
					dropped_cnt++;
				act_cnt[op.act]++;
				ops_taken++;
				phase_due_q.push_back('{op: op, phase: want});
			end
			if (res_ch.valid && res_ch.ready) begin
				if (phase_due_q.size() == 0) begin
					flag_error($sformatf("phase word %0d with nothing expected",
						res_ch.phase_out));
				end else begin
					due = phase_due_q.pop_front();
					if (res_ch.phase_out !== due.phase)
						flag_error($sformatf(
							"%s i=%0d k=%0d g=%0d: phase exp %0d got %0d",
							due.op.act.name(), due.op.row_i, due.op.row_k,
							due.op.gen, due.phase, res_ch.phase_out));
				end
				phases_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus sequence
	// ------------------------------------------------------------------------
	logic [tsre_pkg::NQ_W-1:0] cfg_plan [PHASES] = '{7'd1, 7'd0, 7'd127, 7'd5,
		7'd64, 7'd2, 7'd33, 7'd100, 7'd17};

	initial begin
		int n, wf;
		row_op_t op;
		foreach (tab_x[r]) begin
			tab_x[r] = '0;
			tab_z[r] = '0;
			tab_ph[r] = '0;
			row_filled[r] = 1'b0;
		end
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = tsre_pkg::ACT_COPY;
		item_ch.row_i = '0;
		item_ch.row_k = '0;
		item_ch.generator_index = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed words at the reset qubit count: fill rows first, then
		// every action, the extreme indices and the corner cases
		n = QUBITS;
		push_op(row_op(tsre_pkg::ACT_SET, 0, 0, 0), n);
		push_op(row_op(tsre_pkg::ACT_SET, 1, 0, 127), n);
		push_op(row_op(tsre_pkg::ACT_SET, LAST_ROW, 0, 63), n);
		push_op(row_op(tsre_pkg::ACT_SET, 2, 0, 64), n);
		push_op(row_op(tsre_pkg::ACT_COPY, 3, 0, 0), n);
		push_op(row_op(tsre_pkg::ACT_MUL, 0, 2, 0), n);
		push_op(row_op(tsre_pkg::ACT_MUL, 1, 3, 0), n);
		// row times itself: bits clear, phase doubles
		push_op(row_op(tsre_pkg::ACT_MUL, 3, 3, 0), n);
		push_op(row_op(tsre_pkg::ACT_MUL, 0, 0, 0), n);
		push_op(row_op(tsre_pkg::ACT_SWAP, 0, 1, 0), n);
		// swaps naming the scratch row
		push_op(row_op(tsre_pkg::ACT_SWAP, 2, LAST_ROW, 0), n);
		push_op(row_op(tsre_pkg::ACT_SWAP, LAST_ROW, 1, 0), n);
		push_op(row_op(tsre_pkg::ACT_MUL, 1, 2, 0), n);
		push_op(row_op(tsre_pkg::ACT_SWAP, 0, 0, 0), n);
		push_op(row_op(tsre_pkg::ACT_COPY, 0, 0, 0), n);
		// indices beyond 2n are ignored and return phase 0
		push_op(row_op(tsre_pkg::ACT_COPY, 255, 0, 0), n);
		push_op(row_op(tsre_pkg::ACT_MUL, 0, LAST_ROW + 1, 0), n);
		push_op(row_op(tsre_pkg::ACT_SET, LAST_ROW + 1, 0, 5), n);
		push_op(row_op(tsre_pkg::ACT_SWAP, 200, 255, 0), n);
		// set does not look at row k
		push_op(row_op(tsre_pkg::ACT_SET, 5, 255, 0), n);
		push_op(row_op(tsre_pkg::ACT_MUL, 5, 1, 0), n);
		push_op(row_op(tsre_pkg::ACT_MUL, LAST_ROW, 5, 0), n);
		drain();

		// random phases, one qubit count each, written while idle
		for (int p = 0; p < PHASES; p++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.data <= cfg_plan[p];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			@(negedge clk);
			cfg_ch.valid <= 1'b0;
			n = eff_qubits(cfg_plan[p]);
			wf = 0;
			while (wf < OPS_PER_PHASE) begin
				op = make_op(n);
				push_op(op, n);
				if (!is_dropped(op, n))
					wf++;
			end
			drain();
		end

		$display("run: %0d action words (%0d copy, %0d swap, %0d set, %0d multiply), %0d dropped",
			ops_taken, act_cnt[tsre_pkg::ACT_COPY], act_cnt[tsre_pkg::ACT_SWAP],
			act_cnt[tsre_pkg::ACT_SET], act_cnt[tsre_pkg::ACT_MUL], dropped_cnt);
		$display("run: %0d phase words checked over %0d qubit counts, %0d mismatches",
			phases_checked, PHASES + 1, bad_cnt);
		if (bad_cnt == 0 && phase_due_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
